// ===== rtl/xcfd_pkg.sv =====
// ============================================================================
// xcfd_pkg
// Shared types and constants for the XOR-checked frame deframer.
// ============================================================================
`default_nettype none

package xcfd_pkg;

    // Deframer phase
    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_HEADER  = 2'd1,
        PH_PAYLOAD = 2'd2
    } t_phase;

    // Result kinds
    localparam logic [1:0] KIND_HDR_OK  = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_HDR_BAD = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK           = 2'd0;
    localparam logic [1:0] ST_BAD_PREAMBLE = 2'd1;
    localparam logic [1:0] ST_BAD_HDR_CHK  = 2'd2;
    localparam logic [1:0] ST_BAD_DATA_CHK = 2'd3;

    // Frame start marker '@'
    localparam logic [7:0] MARK_BYTE = 8'h40;

    // Header bytes 1..14 are kept; byte 15 is the header checksum
    localparam int         HDR_STORE_BYTES = 14;
    localparam logic [3:0] HDR_LAST_CNT    = 4'd14;
    localparam logic [3:0] PREAMBLE_LAST   = 4'd2;

    // Write request into the header byte store
    typedef struct packed {
        logic       en;
        logic [3:0] idx;
        logic [7:0] data;
    } t_hdr_wr;

    // Expected preamble bytes after the marker: "NTC"
    function automatic logic [7:0] preamble_byte(input logic [1:0] idx);
        logic [7:0] v;
        case (idx)
            2'd0:    v = 8'h4E;
            2'd1:    v = 8'h54;
            2'd2:    v = 8'h43;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/xcfd_hdr_store.sv =====
// ============================================================================
// xcfd_hdr_store
// Holds header bytes 1..14 and presents the decoded ids, length and data
// checksum as little-endian fields.
// ============================================================================
`default_nettype none

module xcfd_hdr_store
    import xcfd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire t_hdr_wr     i_wr,
    output logic [31:0]      o_receiver,
    output logic [31:0]      o_sender,
    output logic [15:0]      o_length,
    output logic [7:0]       o_data_chk
);

    logic [7:0] r_bytes [HDR_STORE_BYTES];

    // Write one header byte at the collected position
    always_ff @(posedge i_clk) begin
        if (i_wr.en && (i_wr.idx < HDR_LAST_CNT)) begin
            r_bytes[i_wr.idx] <= i_wr.data;
        end
    end

    // Decode fixed fields
    assign o_receiver = {r_bytes[6], r_bytes[5], r_bytes[4], r_bytes[3]};
    assign o_sender   = {r_bytes[10], r_bytes[9], r_bytes[8], r_bytes[7]};
    assign o_length   = {r_bytes[12], r_bytes[11]};
    assign o_data_chk = r_bytes[13];

endmodule

`default_nettype wire

// ===== rtl/xor_checked_frame_deframer_unit.sv =====
// Output: a result is loaded into the output register when its item is
//   accepted and is presented in the next cycle.
// Throughput: one item per cycle; the input stays ready while the output
//   register is empty or being drained in the same cycle.
// Reset: synchronous active-low; returns to idle, clears ids, counters and
//   checksums. Header byte store is not cleared.
// ============================================================================
// xor_checked_frame_deframer_unit
// Byte-serial deframer: finds '@', collects a 16-byte header, checks the
// preamble and XOR checksum, then passes the payload through with a data
// checksum verdict on the last byte.
// ============================================================================
`default_nettype none

module xor_checked_frame_deframer_unit
    import xcfd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_rx_byte,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [1:0]       o_kind,
    output logic [7:0]       o_data_byte,
    output logic             o_last_byte,
    output logic [1:0]       o_status,
    output logic [31:0]      o_sender_id,
    output logic [31:0]      o_receiver_id,
    output logic [15:0]      o_payload_length
);

    // State
    t_phase      r_phase, n_phase;
    logic [3:0]  r_hdr_cnt, n_hdr_cnt;
    logic        r_pre_good, n_pre_good;
    logic [7:0]  r_xor, n_xor;
    logic [15:0] r_bytes_left, n_bytes_left;
    logic [31:0] r_sender, n_sender;
    logic [31:0] r_receiver, n_receiver;

    // Output register
    logic        r_out_valid, n_out_valid;
    logic [1:0]  r_kind, n_kind;
    logic [7:0]  r_data_byte, n_data_byte;
    logic        r_last_byte, n_last_byte;
    logic [1:0]  r_status, n_status;
    logic [15:0] r_length, n_length;

    logic        accept;
    logic        emit;
    logic        hdr_good;
    t_hdr_wr     hdr_wr;
    logic [31:0] st_receiver;
    logic [31:0] st_sender;
    logic [15:0] st_length;
    logic [7:0]  st_data_chk;

    assign o_ready = !r_out_valid || i_ready;
    assign accept  = i_valid && o_ready;

    xcfd_hdr_store u_hdr_store (
        .i_clk      (i_clk),
        .i_wr       (hdr_wr),
        .o_receiver (st_receiver),
        .o_sender   (st_sender),
        .o_length   (st_length),
        .o_data_chk (st_data_chk)
    );

    // Header verdict on the checksum byte
    assign hdr_good = r_pre_good && (r_xor == i_rx_byte);

    // Next phase
    always_comb begin
        n_phase = r_phase;
        if (accept) begin
            case (r_phase)
                PH_HEADER: begin
                    if (r_hdr_cnt == HDR_LAST_CNT) begin
                        n_phase = (hdr_good && (st_length != 16'd0)) ? PH_PAYLOAD : PH_IDLE;
                    end
                end
                PH_PAYLOAD: begin
                    if (r_bytes_left == 16'd1) begin
                        n_phase = PH_IDLE;
                    end
                end
                default: begin
                    n_phase = (i_rx_byte == MARK_BYTE) ? PH_HEADER : PH_IDLE;
                end
            endcase
        end
    end

    // Datapath updates and result
    always_comb begin
        n_hdr_cnt    = r_hdr_cnt;
        n_pre_good   = r_pre_good;
        n_xor        = r_xor;
        n_bytes_left = r_bytes_left;
        n_sender     = r_sender;
        n_receiver   = r_receiver;
        hdr_wr       = '{en: 1'b0, idx: r_hdr_cnt, data: i_rx_byte};
        emit         = 1'b0;
        n_kind       = KIND_HDR_OK;
        n_data_byte  = 8'h00;
        n_last_byte  = 1'b0;
        n_status     = ST_OK;
        n_length     = 16'd0;
        if (accept) begin
            case (r_phase)
                PH_HEADER: begin
                    if (r_hdr_cnt != HDR_LAST_CNT) begin
                        // Collect header byte
                        if ((r_hdr_cnt <= PREAMBLE_LAST)
                                && (i_rx_byte != preamble_byte(r_hdr_cnt[1:0]))) begin
                            n_pre_good = 1'b0;
                        end
                        hdr_wr.en = 1'b1;
                        n_xor     = r_xor ^ i_rx_byte;
                        n_hdr_cnt = r_hdr_cnt + 4'd1;
                    end else begin
                        // Judge header
                        n_hdr_cnt = 4'd0;
                        emit      = 1'b1;
                        if (!r_pre_good) begin
                            n_kind   = KIND_HDR_BAD;
                            n_status = ST_BAD_PREAMBLE;
                        end else if (r_xor != i_rx_byte) begin
                            n_kind   = KIND_HDR_BAD;
                            n_status = ST_BAD_HDR_CHK;
                        end else begin
                            n_receiver   = st_receiver;
                            n_sender     = st_sender;
                            n_bytes_left = st_length;
                            n_xor        = 8'h00;
                            n_length     = st_length;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    // Pass payload byte, check data on the last one
                    emit         = 1'b1;
                    n_xor        = r_xor ^ i_rx_byte;
                    n_bytes_left = r_bytes_left - 16'd1;
                    n_kind       = KIND_PAYLOAD;
                    n_data_byte  = i_rx_byte;
                    n_length     = st_length;
                    if (r_bytes_left == 16'd1) begin
                        n_last_byte = 1'b1;
                        n_status    = ((r_xor ^ i_rx_byte) == st_data_chk)
                                      ? ST_OK : ST_BAD_DATA_CHK;
                    end
                end
                default: begin
                    // Hunt for the marker
                    if (i_rx_byte == MARK_BYTE) begin
                        n_hdr_cnt  = 4'd0;
                        n_pre_good = 1'b1;
                        n_xor      = i_rx_byte;
                    end
                end
            endcase
        end
    end

    // Output valid: load on a new result, drop when taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (emit) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_hdr_cnt    <= 4'd0;
            r_pre_good   <= 1'b1;
            r_xor        <= 8'h00;
            r_bytes_left <= 16'd0;
            r_sender     <= 32'd0;
            r_receiver   <= 32'd0;
            r_out_valid  <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_hdr_cnt    <= n_hdr_cnt;
            r_pre_good   <= n_pre_good;
            r_xor        <= n_xor;
            r_bytes_left <= n_bytes_left;
            r_sender     <= n_sender;
            r_receiver   <= n_receiver;
            r_out_valid  <= n_out_valid;
        end
    end

    // Result payload register
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_kind      <= n_kind;
            r_data_byte <= n_data_byte;
            r_last_byte <= n_last_byte;
            r_status    <= n_status;
            r_length    <= n_length;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_kind           = r_kind;
    assign o_data_byte      = r_data_byte;
    assign o_last_byte      = r_last_byte;
    assign o_status         = r_status;
    assign o_sender_id      = r_sender;
    assign o_receiver_id    = r_receiver;
    assign o_payload_length = r_length;

endmodule

`default_nettype wire

// ===== rtl/xcfd_checker.sv =====
// ============================================================================
// xcfd_checker
// Port-level checks on the deframer's result channel, bound to the top level.
// ============================================================================
`default_nettype none

module xcfd_checker
    import xcfd_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic [1:0]  o_kind,
    input wire logic [7:0]  o_data_byte,
    input wire logic        o_last_byte,
    input wire logic [1:0]  o_status,
    input wire logic [15:0] o_payload_length
);

    // Hold a stalled result
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_kind) && $stable(o_data_byte)
            && $stable(o_status) && $stable(o_payload_length))
        else $error("stalled result changed");

    // Rejected header carries no length and a header error status
    a_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == KIND_HDR_BAD) |->
            (o_payload_length == 16'd0) && !o_last_byte
            && ((o_status == ST_BAD_PREAMBLE) || (o_status == ST_BAD_HDR_CHK)))
        else $error("bad rejected-header result");

    // Data checksum verdict only on the last payload byte
    a_data_chk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_BAD_DATA_CHK) |->
            (o_kind == KIND_PAYLOAD) && o_last_byte)
        else $error("data checksum status outside last payload byte");

    // Header result (ok or bad) has data byte 00, no last-byte flag and a header kind
    a_hdr_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind != KIND_PAYLOAD) |->
            (o_data_byte == 8'h00) && !o_last_byte
            && ((o_kind == KIND_HDR_OK) || (o_kind == KIND_HDR_BAD)))
        else $error("non-payload result malformed");

endmodule

bind xor_checked_frame_deframer_unit xcfd_checker u_xcfd_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_valid          (o_valid),
    .i_ready          (i_ready),
    .o_kind           (o_kind),
    .o_data_byte      (o_data_byte),
    .o_last_byte      (o_last_byte),
    .o_status         (o_status),
    .o_payload_length (o_payload_length)
);

`default_nettype wire

// ===== test/xcfd_event_checker.sv =====
// ----------------------------------------------------------------------------
// xcfd_event_checker
// Watches both channels of the XOR-checked frame deframer. It runs its own
// deframer on every accepted byte and compares each accepted result, field by
// field, with the oldest predicted one.
// ----------------------------------------------------------------------------
module xcfd_event_checker
    import xcfd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_ready,
    input  wire logic [7:0]  i_rx_byte,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_ready,
    input  wire logic [1:0]  i_kind,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_last_byte,
    input  wire logic [1:0]  i_status,
    input  wire logic [31:0] i_sender_id,
    input  wire logic [31:0] i_receiver_id,
    input  wire logic [15:0] i_payload_length,
    output int               o_fail_count,
    output int               o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // "NTC", the preamble bytes that follow the marker
    localparam logic [23:0] NTC_TAIL    = 24'h4E5443;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data_byte;
        logic        last_byte;
        logic [1:0]  status;
        logic [31:0] sender_id;
        logic [31:0] receiver_id;
        logic [15:0] payload_length;
    } t_frame_event;

    t_frame_event frame_events_q[$];
    int           fails   = 0;

    // Deframer state of the prediction
    t_phase      m_phase;
    logic [3:0]  m_hdr_cnt;
    logic        m_pre_ok;
    logic [7:0]  m_xor;
    logic [7:0]  m_hdr [HDR_STORE_BYTES];
    logic [15:0] m_left;
    logic [31:0] m_sender;
    logic [31:0] m_receiver;

    // Advance the deframer by one byte; flag the result it causes, if any
    task automatic deframe_byte(input logic [7:0] b, output bit has_event,
                                output t_frame_event ev);
        ev        = '0;
        has_event = 1'b0;
        case (m_phase)
            PH_HEADER: begin
                if (m_hdr_cnt < HDR_LAST_CNT) begin
                    // collect header bytes 1..14, watching the preamble
                    if (m_hdr_cnt <= PREAMBLE_LAST &&
                        b != NTC_TAIL[23 - 8 * m_hdr_cnt -: 8])
                        m_pre_ok = 1'b0;
                    m_hdr[m_hdr_cnt] = b;
                    m_xor            = m_xor ^ b;
                    m_hdr_cnt        = m_hdr_cnt + 4'd1;
                end else begin
                    // checksum byte: judge the whole header
                    m_phase   = PH_IDLE;
                    m_hdr_cnt = 4'd0;
                    has_event = 1'b1;
                    if (!m_pre_ok) begin
                        ev.kind   = KIND_HDR_BAD;
                        ev.status = ST_BAD_PREAMBLE;
                    end else if (m_xor != b) begin
                        ev.kind   = KIND_HDR_BAD;
                        ev.status = ST_BAD_HDR_CHK;
                    end else begin
                        m_receiver = {m_hdr[6], m_hdr[5], m_hdr[4], m_hdr[3]};
                        m_sender   = {m_hdr[10], m_hdr[9], m_hdr[8], m_hdr[7]};
                        m_left     = {m_hdr[12], m_hdr[11]};
                        m_xor      = 8'h00;
                        if (m_left != 16'd0)
                            m_phase = PH_PAYLOAD;
                        ev.kind           = KIND_HDR_OK;
                        ev.status         = ST_OK;
                        ev.payload_length = m_left;
                    end
                    ev.sender_id   = m_sender;
                    ev.receiver_id = m_receiver;
                end
            end
            PH_PAYLOAD: begin
                // pass the byte on; judge the data checksum on the last one
                m_xor          = m_xor ^ b;
                m_left         = m_left - 16'd1;
                has_event      = 1'b1;
                ev.kind        = KIND_PAYLOAD;
                ev.data_byte   = b;
                ev.status      = ST_OK;
                if (m_left == 16'd0) begin
                    ev.last_byte = 1'b1;
                    ev.status    = (m_xor == m_hdr[13]) ? ST_OK : ST_BAD_DATA_CHK;
                    m_phase      = PH_IDLE;
                end
                ev.payload_length = {m_hdr[12], m_hdr[11]};
                ev.sender_id      = m_sender;
                ev.receiver_id    = m_receiver;
            end
            default: begin
                // idle: only the marker opens a header
                m_phase = PH_IDLE;
                if (b == MARK_BYTE) begin
                    m_phase   = PH_HEADER;
                    m_hdr_cnt = 4'd0;
                    m_pre_ok  = 1'b1;
                    m_xor     = b;
                end
            end
        endcase
    endtask

    function automatic bit field_differs(input string fname, input logic [31:0] want,
                                         input logic [31:0] got);
        if (want === got)
            return 1'b0;
        $display("t=%0t: %s expected %0h, got %0h", $time, fname, want, got);
        return 1'b1;
    endfunction

    // Check results first, then predict from the byte taken at this edge
    always @(posedge i_clk) begin : watch
        t_frame_event got;
        t_frame_event want;
        t_frame_event ev;
        bit           has_ev;
        bit           bad;
        if (!i_rst_n) begin
            m_phase    = PH_IDLE;
            m_hdr_cnt  = 4'd0;
            m_pre_ok   = 1'b1;
            m_xor      = 8'h00;
            m_left     = 16'd0;
            m_sender   = 32'd0;
            m_receiver = 32'd0;
            frame_events_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                got = {i_kind, i_data_byte, i_last_byte, i_status, i_sender_id,
                       i_receiver_id, i_payload_length};
                if (frame_events_q.size() == 0) begin
                    $display("t=%0t: result expected none, got %0h", $time, got);
                    fails++;
                end else begin
                    want = frame_events_q.pop_front();
                    bad  = field_differs("kind", want.kind, got.kind)
                         | field_differs("data_byte", want.data_byte, got.data_byte)
                         | field_differs("last_byte", want.last_byte, got.last_byte)
                         | field_differs("status", want.status, got.status)
                         | field_differs("sender_id", want.sender_id, got.sender_id)
                         | field_differs("receiver_id", want.receiver_id, got.receiver_id)
                         | field_differs("payload_length", want.payload_length,
                                         got.payload_length);
                    if (bad)
                        fails++;
                end
            end
            if (i_in_valid && i_in_ready) begin
                deframe_byte(i_rx_byte, has_ev, ev);
                if (has_ev)
                    frame_events_q.push_back(ev);
            end
        end
        o_fail_count <= fails;
        o_pending    <= frame_events_q.size();
    end

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Drives byte streams into the XOR-checked frame deframer: directed frames
// for each header and payload case, then random frames, noise and cut-off
// headers with random idling on both channels, one long receiver hold-off,
// and a calm tail of closing frames. A checker gives the verdict.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import xcfd_pkg::*;

    typedef enum int {
        FAULT_NONE,
        FAULT_PREAMBLE,
        FAULT_HDR_CHK,
        FAULT_BOTH,
        FAULT_DATA_CHK
    } t_fault;

    localparam int FILL_RANDOM    = -1;
    localparam int RANDOM_ITEMS   = 360;
    localparam int HOLD_OFF_TICKS = 64;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        byte_valid  = 1'b0;
    logic        byte_ready;
    logic [7:0]  rx_byte     = 8'h00;
    logic        evt_valid;
    logic        evt_ready   = 1'b0;
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [1:0]  status;
    logic [31:0] sender_id;
    logic [31:0] receiver_id;
    logic [15:0] payload_length;
    int          fail_count;
    int          pending;

    logic [7:0]  link_q[$];
    int          hold_at   = -1;
    int          calm_from = -1;
    bit          hold_req  = 1'b0;
    bit          calm      = 1'b0;
    int          idx;
    int          pick;

    xor_checked_frame_deframer_unit dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_valid          (byte_valid),
        .o_ready          (byte_ready),
        .i_rx_byte        (rx_byte),
        .o_valid          (evt_valid),
        .i_ready          (evt_ready),
        .o_kind           (kind),
        .o_data_byte      (data_byte),
        .o_last_byte      (last_byte),
        .o_status         (status),
        .o_sender_id      (sender_id),
        .o_receiver_id    (receiver_id),
        .o_payload_length (payload_length)
    );

    xcfd_event_checker event_check (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (byte_valid),
        .i_in_ready       (byte_ready),
        .i_rx_byte        (rx_byte),
        .i_out_valid      (evt_valid),
        .i_out_ready      (evt_ready),
        .i_kind           (kind),
        .i_data_byte      (data_byte),
        .i_last_byte      (last_byte),
        .i_status         (status),
        .i_sender_id      (sender_id),
        .i_receiver_id    (receiver_id),
        .i_payload_length (payload_length),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Append one frame: header, then payload; faults corrupt a chosen part
    task automatic add_frame(input logic [15:0] len, input logic [31:0] rcv_id,
                             input logic [31:0] snd_id, input t_fault fault,
                             input int fill);
        logic [7:0] hdr [16];
        logic [7:0] body [$];
        logic [7:0] sum;
        logic [7:0] v;
        sum = 8'h00;
        for (int k = 0; k < len; k++) begin
            v = (fill == FILL_RANDOM) ? 8'($urandom_range(0, 255)) : 8'(fill);
            body.push_back(v);
            sum = sum ^ v;
        end
        hdr[0] = MARK_BYTE;
        hdr[1] = 8'h4E;
        hdr[2] = 8'h54;
        hdr[3] = 8'h43;
        for (int k = 0; k < 4; k++) begin
            hdr[4 + k] = rcv_id[8 * k +: 8];
            hdr[8 + k] = snd_id[8 * k +: 8];
        end
        hdr[12] = len[7:0];
        hdr[13] = len[15:8];
        hdr[14] = sum;
        if (fault == FAULT_DATA_CHK)
            hdr[14] = sum ^ 8'($urandom_range(1, 255));
        if (fault == FAULT_PREAMBLE || fault == FAULT_BOTH) begin
            v = 8'($urandom_range(1, 3));
            hdr[v] = hdr[v] ^ 8'($urandom_range(1, 255));
        end
        hdr[15] = 8'h00;
        for (int k = 0; k < 15; k++)
            hdr[15] = hdr[15] ^ hdr[k];
        if (fault == FAULT_HDR_CHK || fault == FAULT_BOTH)
            hdr[15] = hdr[15] ^ 8'($urandom_range(1, 255));
        for (int k = 0; k < 16; k++)
            link_q.push_back(hdr[k]);
        for (int k = 0; k < len; k++)
            link_q.push_back(body[k]);
    endtask

    task automatic build_stream();
        t_fault fault;
        int     len;
        // idle bytes around the marker value are dropped
        link_q.push_back(8'h00);
        link_q.push_back(8'hFF);
        link_q.push_back(8'h3F);
        link_q.push_back(8'h41);
        // zero-length payload, extreme ids
        add_frame(16'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, FAULT_NONE, FILL_RANDOM);
        add_frame(16'd1, 32'h0000_0000, 32'h0000_0000, FAULT_DATA_CHK, 8'hFF);
        // rejected headers keep the stored ids
        add_frame(16'd0, 32'h1234_5678, 32'h9ABC_DEF0, FAULT_PREAMBLE, FILL_RANDOM);
        add_frame(16'd0, 32'h1234_5678, 32'h9ABC_DEF0, FAULT_HDR_CHK, FILL_RANDOM);
        add_frame(16'd0, 32'h1234_5678, 32'h9ABC_DEF0, FAULT_BOTH, FILL_RANDOM);
        // markers inside header and payload are ordinary bytes
        add_frame(16'd3, 32'h4040_4040, 32'h4040_4040, FAULT_NONE, MARK_BYTE);
        add_frame(16'd2, 32'h8000_0001, 32'h0000_00FF, FAULT_NONE, 8'h00);

        // the receiver holds off from the first payload byte of this frame
        hold_at = link_q.size() + 16;
        add_frame(16'd10, $urandom, $urandom, FAULT_NONE, FILL_RANDOM);

        // random part: mostly well-formed frames, some noise and cut headers
        while (link_q.size() < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64)
                                                  : $urandom_range(0, 12);
                case ($urandom_range(0, 9))
                    0:       fault = FAULT_PREAMBLE;
                    1:       fault = FAULT_HDR_CHK;
                    2:       fault = FAULT_BOTH;
                    3:       fault = FAULT_DATA_CHK;
                    default: fault = FAULT_NONE;
                endcase
                add_frame(16'(len), $urandom, $urandom, fault, FILL_RANDOM);
            end else if (pick < 85) begin
                repeat ($urandom_range(1, 6))
                    link_q.push_back(8'($urandom_range(0, 255)));
            end else begin
                link_q.push_back(MARK_BYTE);
                link_q.push_back(8'h4E);
                repeat ($urandom_range(0, 13))
                    link_q.push_back(8'($urandom_range(0, 255)));
            end
        end

        // calm tail: flush any cut header, then a few closing frames
        calm_from = link_q.size();
        repeat (16)
            link_q.push_back(8'h00);
        add_frame(16'd4, $urandom, $urandom, FAULT_NONE, FILL_RANDOM);
        add_frame(16'd24, $urandom, $urandom,
                  ($urandom_range(0, 1) == 0) ? FAULT_NONE : FAULT_DATA_CHK, FILL_RANDOM);
        add_frame(16'd0, $urandom, $urandom, FAULT_NONE, FILL_RANDOM);
    endtask

    // Offer one item, with an optional idle burst before it
    task automatic push_byte(input logic [7:0] b);
        if (!calm && $urandom_range(0, 3) == 0) begin
            byte_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clk);
        end
        byte_valid <= 1'b1;
        rx_byte    <= b;
        @(posedge clk);
        while (!byte_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Stimulus and verdict
    initial begin
        build_stream();
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        for (idx = 0; idx < link_q.size(); idx++) begin
            if (idx == hold_at)
                hold_req = 1'b1;
            if (idx == calm_from)
                calm = 1'b1;
            push_byte(link_q[idx]);
        end
        byte_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

    // Receiver: random stall bursts, one long hold-off, none in the tail
    initial begin
        forever begin
            @(negedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                evt_ready <= 1'b0;
                repeat (HOLD_OFF_TICKS) @(negedge clk);
                evt_ready <= 1'b1;
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                evt_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(negedge clk);
                evt_ready <= 1'b1;
            end else begin
                evt_ready <= 1'b1;
            end
        end
    end

    // Watchdog
    initial begin
        #1_000_000;
        $display("tb failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/xcfd_pkg.sv
rtl/xcfd_hdr_store.sv
rtl/xor_checked_frame_deframer_unit.sv
rtl/xcfd_checker.sv
test/xcfd_event_checker.sv
test/tb.sv
